// ----- rtl/weighted_tile_picker_macros.svh -----
// Assertion macros shared by the weighted tile picker checker.
`ifndef WEIGHTED_TILE_PICKER_MACROS_SVH
`define WEIGHTED_TILE_PICKER_MACROS_SVH

// Clocked property, switched off while reset is high.
`define WTP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define WTP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/wtp_pkg.sv -----
// Shared types and constants of the weighted tile picker.
package wtp_pkg;

  localparam int TILE_W   = 3;              // tile_index / current_tile width
  localparam int TILE_LIM = 1 << TILE_W;    // tiles a click can address
  localparam int DRAW_W   = 15;             // random_value width
  localparam int TOTAL_W  = 7;              // total_weight width
  localparam int ACT_W    = 2;

  localparam logic [ACT_W-1:0] ACT_LEFT  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RIGHT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PICK  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd3;

  // Weight update broadcast to every cell.
  typedef struct packed {
    logic              inc;
    logic              dec;
    logic              clr;
    logic [TILE_W-1:0] tile;
  } cell_cmd_t;

  // Selection carried down the chain during a pick.
  typedef struct packed {
    logic              done;
    logic [TILE_W-1:0] tile;
  } trail_t;

endpackage

// ----- rtl/wtp_if.sv -----
// Command and result channel interfaces of the weighted tile picker.
interface wtp_cmd_if;
  logic                      valid;
  logic                      ready;
  logic [wtp_pkg::ACT_W-1:0] action;
  logic [wtp_pkg::TILE_W-1:0] tile_index;
  logic                      shift_held;
  logic [wtp_pkg::DRAW_W-1:0] random_value;

  modport source (output valid, action, tile_index, shift_held, random_value, input ready);
  modport sink   (input valid, action, tile_index, shift_held, random_value, output ready);
endinterface

interface wtp_res_if;
  logic                        valid;
  logic                        ready;
  logic [wtp_pkg::TILE_W-1:0]  current_tile;
  logic [wtp_pkg::TOTAL_W-1:0] total_weight;
  logic                        weighted_mode;

  modport source (output valid, current_tile, total_weight, weighted_mode, input ready);
  modport sink   (input valid, current_tile, total_weight, weighted_mode, output ready);
endinterface

// ----- rtl/wtp_cell.sv -----
// One tile cell: holds its weight and does one step of the cumulative walk.
module wtp_cell #(
  parameter int IDX      = 0,
  parameter int WEIGHT_W = 4,
  parameter int SUM_W    = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  wtp_pkg::cell_cmd_t cmd,
  input  logic [SUM_W-1:0]   draw,
  input  logic [SUM_W-1:0]   cum_in,
  input  wtp_pkg::trail_t    trail_in,
  output logic [SUM_W-1:0]   cum_out,
  output wtp_pkg::trail_t    trail_out,
  output logic [WEIGHT_W-1:0] weight
);

  localparam bit REACH = IDX < wtp_pkg::TILE_LIM;

  logic             match;
  logic [SUM_W-1:0] cum_next;

  assign match    = REACH && (cmd.tile == wtp_pkg::TILE_W'(IDX));
  assign cum_next = cum_in + SUM_W'(weight);

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= '0;
    end else if (cmd.clr) begin
      weight <= '0;
    end else if (match && cmd.inc) begin
      weight <= weight + WEIGHT_W'(1);
    end else if (match && cmd.dec) begin
      weight <= weight - WEIGHT_W'(1);
    end
  end

  // First cell whose running total passes the draw claims the selection.
  always_ff @(posedge clk) begin
    if (rst) begin
      trail_out <= '0;
      cum_out   <= '0;
    end else begin
      cum_out <= cum_next;
      if (!trail_in.done && (cum_next > draw)) begin
        trail_out.done <= 1'b1;
        trail_out.tile <= wtp_pkg::TILE_W'(IDX);
      end else begin
        trail_out <= trail_in;
      end
    end
  end

endmodule

// ----- rtl/wtp_mod.sv -----
// Restoring remainder unit: draw mod total, one dividend bit per cycle.
module wtp_mod #(
  parameter int SUM_W = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [wtp_pkg::DRAW_W-1:0] dividend,
  input  logic [SUM_W-1:0]           divisor,
  output logic                       busy,
  output logic [SUM_W-1:0]           rem
);

  localparam int CNT_W = $clog2(wtp_pkg::DRAW_W);

  logic [wtp_pkg::DRAW_W-1:0] shreg;
  logic [CNT_W-1:0]           cnt;
  logic [SUM_W:0]             trial;

  assign trial = {rem, shreg[wtp_pkg::DRAW_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(wtp_pkg::DRAW_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[wtp_pkg::DRAW_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem <= SUM_W'(trial - {1'b0, divisor});
      end else begin
        rem <= SUM_W'(trial);
      end
    end
  end

endmodule

// ----- rtl/weighted_tile_picker.sv -----
// Weighted tile picker top level: command handling, remainder unit and cell chain.
//
// Usage:
//   cmd channel takes one item per user action (left click, right click,
//   pick, clear weights); res channel returns one item per command with the
//   current tile, the weight total (low 7 bits) and the weighted-mode flag
//   as they stand after that command.
// Sequence:
//   click, clear and zero-total pick items: go straight to posting the result.
//   pick otherwise: one remainder step per dividend bit in the serial
//   remainder unit, then the cumulative walk along the cell chain, one
//   cell per cycle; the result is loaded once the output register is free.
//   cmd.ready is high only while no item is in work.
// Reset: rst clears all weights, total, mode and current tile, and drops
//   res.valid.
// Stall: a result held by a stalled receiver stays in the output register;
//   one more item may be accepted and worked on, and its result waits
//   until the register frees up.
module weighted_tile_picker #(
  parameter int NUM_TILES  = 8,
  parameter int MAX_WEIGHT = 10
) (
  input logic       clk,
  input logic       rst,
  wtp_cmd_if.sink   cmd,
  wtp_res_if.source res
);

  localparam int WEIGHT_W = $clog2(MAX_WEIGHT + 1);
  localparam int SUM_W    = $clog2(NUM_TILES * MAX_WEIGHT + 1);
  localparam int WCNT_W   = $clog2(NUM_TILES + 1);

  // sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOD  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_POST = 2'd3;

  logic [1:0]                  state;
  logic [WCNT_W-1:0]           wcnt;
  logic [SUM_W-1:0]            sum;
  logic                        active;
  logic [wtp_pkg::TILE_W-1:0]  paste;

  logic                        fire;
  logic                        tile_ok;
  logic                        boost;       // left click lands in weighted mode
  logic [WEIGHT_W-1:0]         sel_w;
  wtp_pkg::cell_cmd_t          ccmd;
  logic                        mod_start;
  logic                        mod_busy;
  logic [SUM_W-1:0]            draw;

  logic [WEIGHT_W-1:0]         weights [NUM_TILES];
  logic [SUM_W-1:0]            cum     [NUM_TILES+1];
  wtp_pkg::trail_t             trail   [NUM_TILES+1];

  assign cmd.ready = (state == S_IDLE);
  assign fire      = cmd.valid && cmd.ready;
  assign tile_ok   = {29'd0, cmd.tile_index} < 32'(NUM_TILES);
  assign boost     = active || cmd.shift_held;

  // weight of the clicked tile
  always_comb begin
    sel_w = '0;
    for (int i = 0; i < NUM_TILES; i++) begin
      if ((i < wtp_pkg::TILE_LIM) && (cmd.tile_index == wtp_pkg::TILE_W'(i))) begin
        sel_w = weights[i];
      end
    end
  end

  always_comb begin
    ccmd.tile = cmd.tile_index;
    ccmd.clr  = fire && ((cmd.action == wtp_pkg::ACT_CLEAR) ||
                ((cmd.action == wtp_pkg::ACT_LEFT) && tile_ok && !boost));
    ccmd.inc  = fire && (cmd.action == wtp_pkg::ACT_LEFT) && tile_ok && boost &&
                (sel_w < WEIGHT_W'(MAX_WEIGHT));
    ccmd.dec  = fire && (cmd.action == wtp_pkg::ACT_RIGHT) && tile_ok &&
                (sel_w != '0);
  end

  assign mod_start = fire && (cmd.action == wtp_pkg::ACT_PICK) && (sum != '0);

  wtp_mod #(.SUM_W(SUM_W)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (cmd.random_value),
    .divisor  (sum),
    .busy     (mod_busy),
    .rem      (draw)
  );

  // cell chain: running total and selection ripple one cell per cycle
  assign cum[0]   = '0;
  assign trail[0] = '0;

  for (genvar g = 0; g < NUM_TILES; g++) begin : g_cell
    wtp_cell #(.IDX(g), .WEIGHT_W(WEIGHT_W), .SUM_W(SUM_W)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (ccmd),
      .draw      (draw),
      .cum_in    (cum[g]),
      .trail_in  (trail[g]),
      .cum_out   (cum[g+1]),
      .trail_out (trail[g+1]),
      .weight    (weights[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wcnt      <= '0;
      sum       <= '0;
      active    <= 1'b0;
      paste     <= '0;
      res.valid <= 1'b0;
    end else begin
      // post a new result, or drop the one just taken
      if ((state == S_POST) && (!res.valid || res.ready)) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (fire) begin
            state <= mod_start ? S_MOD : S_POST;
            if ((cmd.action == wtp_pkg::ACT_LEFT) && tile_ok) begin
              paste <= cmd.tile_index;
              if (boost) begin
                active <= 1'b1;
              end
            end
            if (ccmd.clr) begin
              sum    <= '0;
              active <= 1'b0;
            end else if (ccmd.inc) begin
              sum <= sum + SUM_W'(1);
            end else if (ccmd.dec) begin
              sum <= sum - SUM_W'(1);
            end
          end
        end
        S_MOD: begin
          if (!mod_busy) begin
            state <= S_WALK;
            wcnt  <= '0;
          end
        end
        S_WALK: begin
          // last cell holds the answer once the walk counter reaches NUM_TILES
          if (wcnt == WCNT_W'(NUM_TILES)) begin
            if (trail[NUM_TILES].done) begin
              paste <= trail[NUM_TILES].tile;
            end
            state <= S_POST;
          end else begin
            wcnt <= wcnt + WCNT_W'(1);
          end
        end
        S_POST: begin
          if (!res.valid || res.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result payload, loaded as the result is posted
  always_ff @(posedge clk) begin
    if ((state == S_POST) && (!res.valid || res.ready)) begin
      res.current_tile  <= paste;
      res.total_weight  <= wtp_pkg::TOTAL_W'(sum);
      res.weighted_mode <= active;
    end
  end

endmodule

// ----- rtl/wtp_checker.sv -----
// Port-level checker of the weighted tile picker and its bind.
`include "weighted_tile_picker_macros.svh"

module wtp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        cmd_valid,
  input logic                        cmd_ready,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [wtp_pkg::TILE_W-1:0]  res_current_tile,
  input logic [wtp_pkg::TOTAL_W-1:0] res_total_weight,
  input logic                        res_weighted_mode
);

  `WTP_ASSERT(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid, "result dropped while stalled")
  `WTP_ASSERT(a_res_stable, clk, rst, res_valid && !res_ready |=> $stable(res_current_tile) && $stable(res_total_weight) && $stable(res_weighted_mode), "stalled result changed")
  `WTP_ASSERT(a_one_at_a_time, clk, rst, cmd_valid && cmd_ready |=> !cmd_ready, "second item taken while busy")
  `WTP_ASSERT(a_mode_total, clk, rst, res_valid && !res_weighted_mode |-> res_total_weight == '0, "weights present outside weighted mode")
  `WTP_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !res_valid && cmd_ready, "reset did not idle the block")

endmodule

bind weighted_tile_picker wtp_checker u_wtp_checker (
  .clk               (clk),
  .rst               (rst),
  .cmd_valid         (cmd.valid),
  .cmd_ready         (cmd.ready),
  .res_valid         (res.valid),
  .res_ready         (res.ready),
  .res_current_tile  (res.current_tile),
  .res_total_weight  (res.total_weight),
  .res_weighted_mode (res.weighted_mode)
);
